@@ hw/rtl/vrr_pkg.sv @@
// Shared types, codes and field widths for the VOQ round-robin selector.
package vrr_pkg;

    // Default configuration of the selector.
    localparam int NUM_PORTS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 1024;

    // Fixed field widths of the stream items.
    localparam int FUNC_W   = 2;
    localparam int DST_W    = 4;
    localparam int STATUS_W = 2;
    localparam int SEL_W    = 4;
    localparam int DCNT_W   = 11;
    localparam int TOTAL_W  = 15;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_SAMPLE = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [SEL_W-1:0]    selected;
        logic                selected_valid;
        logic [DCNT_W-1:0]   dst_count;
        logic [TOTAL_W-1:0]  total_count;
    } result_t;

endpackage

@@ hw/rtl/vrr_core.sv @@
// Queue counters, rotation ring and combinational operation logic of the selector.
module vrr_core #(
    parameter int NUM_PORTS   = vrr_pkg::NUM_PORTS_DEF,
    parameter int QUEUE_DEPTH = vrr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  vrr_pkg::func_t             func,
    input  logic [vrr_pkg::DST_W-1:0]  dst,
    output vrr_pkg::result_t           res
);

    localparam int IDX_W   = $clog2(NUM_PORTS);
    localparam int OCC_W   = $clog2(NUM_PORTS + 1);
    localparam int SUM_W   = OCC_W + 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W   = $clog2(NUM_PORTS * QUEUE_DEPTH + 1);
    localparam int DST_W   = vrr_pkg::DST_W;
    localparam int CMP_W   = DST_W + IDX_W;
    localparam int DCNT_W  = vrr_pkg::DCNT_W;
    localparam int TOTAL_W = vrr_pkg::TOTAL_W;

    logic [CNT_W-1:0] cnt_reg [NUM_PORTS];
    logic [DST_W-1:0] ring_mem [NUM_PORTS];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [TOT_W-1:0] total_reg, total_next;

    logic [CMP_W-1:0] dst_ext;
    logic             dst_ok;
    logic [IDX_W-1:0] dst_idx;
    logic [CNT_W-1:0] cnt_rd;
    logic [CNT_W-1:0] cnt_wr;
    logic             cnt_we;
    logic             clr;

    logic [IDX_W-1:0] tail_pos;
    logic [IDX_W-1:0] back_pos;
    logic [IDX_W-1:0] ring_raddr;
    logic [DST_W-1:0] ring_rd;
    logic             ring_we;
    logic [DST_W-1:0] ring_wdata;

    vrr_pkg::status_t status;
    logic [DST_W-1:0] sel;
    logic             sel_valid;
    logic [CNT_W-1:0] dcount;

    // Position base + offs modulo the ring size; base is below the size and offs is at most the size.
    function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W-1:0] base,
                                                   input logic [OCC_W-1:0] offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(NUM_PORTS)) begin
            sum = sum - SUM_W'(NUM_PORTS);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign dst_ext = CMP_W'(dst);
    assign dst_ok  = dst_ext < CMP_W'(NUM_PORTS);
    assign dst_idx = dst_ext[IDX_W-1:0];
    assign cnt_rd  = dst_ok ? cnt_reg[dst_idx] : '0;

    // The back entry is the most recently appended or rotated output.
    assign tail_pos   = ring_wrap(head_reg, occ_reg);
    assign back_pos   = ring_wrap(head_reg, occ_reg - OCC_W'(1));
    assign ring_raddr = (func == vrr_pkg::FN_SAMPLE) ? head_reg : back_pos;
    assign ring_rd    = ring_mem[ring_raddr];

    always_comb begin
        head_next  = head_reg;
        occ_next   = occ_reg;
        total_next = total_reg;
        cnt_wr     = cnt_rd;
        cnt_we     = 1'b0;
        clr        = 1'b0;
        ring_we    = 1'b0;
        ring_wdata = dst;
        status     = vrr_pkg::ST_OK;
        sel        = '0;
        sel_valid  = 1'b0;
        case (func)
            vrr_pkg::FN_ADD: begin
                if (!dst_ok) begin
                    status = vrr_pkg::ST_INVALID;
                end else if (cnt_rd >= CNT_W'(QUEUE_DEPTH)) begin
                    status = vrr_pkg::ST_FULL;
                end else begin
                    if (cnt_rd == '0 && occ_reg < OCC_W'(NUM_PORTS)) begin
                        ring_we  = en;
                        occ_next = occ_reg + OCC_W'(1);
                    end
                    cnt_wr     = cnt_rd + CNT_W'(1);
                    cnt_we     = en;
                    total_next = total_reg + TOT_W'(1);
                end
            end
            vrr_pkg::FN_REMOVE: begin
                if (!dst_ok || occ_reg == '0 || ring_rd != dst || cnt_rd == '0) begin
                    status = vrr_pkg::ST_INVALID;
                end else begin
                    cnt_wr     = cnt_rd - CNT_W'(1);
                    cnt_we     = en;
                    total_next = total_reg - TOT_W'(1);
                    if (cnt_rd == CNT_W'(1)) begin
                        occ_next = occ_reg - OCC_W'(1);
                    end
                end
            end
            vrr_pkg::FN_SAMPLE: begin
                if (occ_reg == '0) begin
                    status = vrr_pkg::ST_EMPTY;
                end else begin
                    sel        = ring_rd;
                    sel_valid  = 1'b1;
                    ring_we    = en;
                    ring_wdata = ring_rd;
                    head_next  = ring_wrap(head_reg, OCC_W'(1));
                end
            end
            vrr_pkg::FN_CLEAR: begin
                clr        = 1'b1;
                head_next  = '0;
                occ_next   = '0;
                total_next = '0;
            end
            default: begin
                status = vrr_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        if (!dst_ok || clr) begin
            dcount = '0;
        end else begin
            dcount = cnt_wr;
        end
    end

    assign res.status         = status;
    assign res.selected       = sel;
    assign res.selected_valid = sel_valid;
    assign res.dst_count      = DCNT_W'(dcount);
    assign res.total_count    = TOTAL_W'(total_next);

    always_ff @(posedge aclk) begin
        if (!aresetn || (en && clr)) begin
            head_reg  <= '0;
            occ_reg   <= '0;
            total_reg <= '0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (en) begin
            head_reg  <= head_next;
            occ_reg   <= occ_next;
            total_reg <= total_next;
            if (cnt_we) begin
                cnt_reg[dst_idx] <= cnt_wr;
            end
        end
    end

    // Ring contents are only meaningful below the occupancy, so no reset.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[tail_pos] <= ring_wdata;
        end
    end

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(NUM_PORTS))
        else $error("ring occupancy exceeds the number of outputs");

    a_empty_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg == '0) == (occ_reg == '0))
        else $error("ring occupancy disagrees with the total packet count");

    a_sample_rotates: assert property (@(posedge aclk) disable iff (!aresetn)
        en && func == vrr_pkg::FN_SAMPLE && occ_reg != '0 |=> head_reg != $past(head_reg))
        else $error("successful sample did not advance the ring head");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        en && status == vrr_pkg::ST_FULL |=> total_reg == $past(total_reg))
        else $error("add to a full counter changed the total");

    a_last_remove_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        en && func == vrr_pkg::FN_REMOVE && status == vrr_pkg::ST_OK && cnt_rd == CNT_W'(1)
        |=> occ_reg == $past(occ_reg) - OCC_W'(1))
        else $error("last remove of an output did not drop its ring entry");
`endif

endmodule

@@ hw/rtl/voq_round_robin_selector_top.sv @@
// Top level of the VOQ round-robin selector with its stream ports and result register.
//
// The selector keeps a packet count for each output queue, a running total and a
// rotation ring that holds every non-empty output once. Each input transfer carries
// one operation (add, remove, sample or clear) and produces exactly one result
// transfer with a status, the sampled output, the count of the named output and the
// total. The operation is decoded, checked and applied to the counters and the ring
// in the cycle it is accepted, and its result is captured in a single output
// register, so one transfer per clock is sustained while the result side keeps
// taking them. The input is ready whenever the output register is empty or is being
// drained in the same cycle; that register is the only thing that can hold the
// input back. A remove is valid only for the output that sits at the back of the
// ring, which is the most recently appended or sampled output still in the ring.
// No clearing pass follows reset: all counters clear at once.
module voq_round_robin_selector_top #(
    parameter int NUM_PORTS   = vrr_pkg::NUM_PORTS_DEF,
    parameter int QUEUE_DEPTH = vrr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: func [1:0], dst [5:2], zero pad [7:6]
    input  logic [vrr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status [1:0], selected [5:2], selected_valid [6],
    // dst_count [17:7], total_count [32:18], zero pad [39:33]
    output logic [vrr_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int FUNC_W = vrr_pkg::FUNC_W;
    localparam int DST_W  = vrr_pkg::DST_W;
    localparam int PAD_W  = vrr_pkg::M_TDATA_W - vrr_pkg::STATUS_W - vrr_pkg::SEL_W - 1
                            - vrr_pkg::DCNT_W - vrr_pkg::TOTAL_W;

    logic             in_xfer;
    vrr_pkg::func_t   in_func;
    logic [DST_W-1:0] in_dst;
    vrr_pkg::result_t res;

    vrr_pkg::result_t res_reg;
    logic             m_tvalid_reg, m_tvalid_next;

    // The result register accepts a new item when it is empty or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign in_func  = vrr_pkg::func_t'(s_tdata[FUNC_W-1:0]);
    assign in_dst   = s_tdata[FUNC_W +: DST_W];

    vrr_core #(
        .NUM_PORTS   (NUM_PORTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (in_xfer),
        .func    (in_func),
        .dst     (in_dst),
        .res     (res)
    );

    always_comb begin
        if (in_xfer) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload is only captured on an accepted input transfer.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {PAD_W'(0), res_reg.total_count, res_reg.dst_count,
                       res_reg.selected_valid, res_reg.selected, res_reg.status};

endmodule
